// ===== rtl/ovn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ovn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W    = 32;
  localparam int PERS_W     = 18;
  localparam int FREQ_W     = 24;
  localparam int OCT_W      = 4;
  localparam int SEED_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int HEIGHT_W   = 32;

  // scaled coordinate: magnitude times frequency
  localparam int PROD_W = COORD_W + FREQ_W;

  // amplitude, unsigned Q22.16 with a cap
  localparam int AMP_W = 38;
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
  localparam logic [AMP_W-1:0] AMP_CAP = {AMP_W{1'b1}};

  // corner sums are exact in units of 2^-34
  localparam int CW = 37;
  // octave value in Q3.24
  localparam int VW = CW - 10;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
  localparam logic [31:0] HASH_BIAS  = 32'h40000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERSISTENCE    = 3'd0,
    REG_BASE_FREQUENCY = 3'd1,
    REG_OCTAVE_COUNT   = 3'd2,
    REG_SEED_OFFSET    = 3'd3
  } cfg_reg_t;

  // per-octave tag that travels with each item through the pipeline
  typedef struct packed {
    logic live;   // octave contributes (clear for a zero octave count)
    logic first;  // first octave of its point
    logic last;   // last octave of its point
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/ovn_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovn_hash (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [31:0]        x,
  input  wire logic [31:0]        y,
  output logic signed [31:0]      val
);
  import ovn_pkg::*;

  logic [31:0] n_mix;
  logic [31:0] n1_r, n2_r, n3_r;
  logic [31:0] sq_r, u_r, m_r;
  logic [31:0] t_nxt;
  logic signed [31:0] val_r;

  assign n_mix = x + y * HASH_MUL_Y;
  assign t_nxt = (m_r + HASH_ADD_B) & HASH_MASK;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= (n_mix << 13) ^ n_mix;
      sq_r  <= n1_r * n1_r;
      n2_r  <= n1_r;
      u_r   <= sq_r * HASH_MUL_A + HASH_ADD_A;
      n3_r  <= n2_r;
      m_r   <= n3_r * u_r;
      val_r <= signed'(HASH_BIAS - t_nxt);
    end
  end

  assign val = val_r;

endmodule
`default_nettype wire

// ===== rtl/ovn_issue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovn_issue #(
  parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = ovn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ovn_pkg::COORD_W-1:0]   coord_x,
  input  wire logic [ovn_pkg::COORD_W-1:0]   coord_y,
  input  wire logic [ovn_pkg::PERS_W-1:0]    persistence,
  input  wire logic [ovn_pkg::FREQ_W-1:0]    base_frequency,
  input  wire logic [ovn_pkg::OCT_W-1:0]     octave_count,
  input  wire logic [ovn_pkg::SEED_W-1:0]    seed_offset,
  output logic                               tok_valid,
  output ovn_pkg::tag_t                      tok_tag,
  output logic [31:0]                        tok_x,
  output logic [31:0]                        tok_y,
  output logic [FRAC_BITS-1:0]               tok_xf,
  output logic [FRAC_BITS-1:0]               tok_yf,
  output logic [ovn_pkg::AMP_W-1:0]          tok_amp
);
  import ovn_pkg::*;

  localparam int CNTW = $clog2(MAX_OCTAVES + 1);
  localparam int SW   = 64 + MAX_OCTAVES + FRAC_BITS;

  logic                 buf_v_r;
  logic [COORD_W-1:0]   mag_x_r, mag_y_r;
  logic [COORD_W-1:0]   mag_x, mag_y;
  logic                 busy_r;
  logic [PROD_W-1:0]    px_r, py_r;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [CNTW-1:0]      k_r;
  logic [AMP_W-1:0]     amp_r, amp_nxt;
  logic                 last;
  logic                 load;
  logic                 in_acc;
  logic [SW-1:0]        sx, sy;
  logic [PERS_W+19-1:0] amp_hi_p, amp_lo_p;
  logic [AMP_W+PERS_W:0] amp_prod;
  logic [AMP_W+2:0]     amp_shr;

  assign mag_x = coord_x[COORD_W-1] ? (~coord_x + 1'b1) : coord_x;
  assign mag_y = coord_y[COORD_W-1] ? (~coord_y + 1'b1) : coord_y;

  assign last   = (cnt_r == '0) || (k_r == cnt_r - 1'b1);
  assign load   = en && buf_v_r && (!busy_r || last);
  assign in_stall = buf_v_r && !load;
  assign in_acc = in_valid && !in_stall;

  assign cnt_nxt = (int'(octave_count) > MAX_OCTAVES) ? CNTW'(MAX_OCTAVES)
                                                      : CNTW'(octave_count);

  // amplitude step split into two narrow products
  assign amp_hi_p = amp_r[AMP_W-1:19] * persistence;
  assign amp_lo_p = amp_r[18:0] * persistence;
  assign amp_prod = ((AMP_W+PERS_W+1)'(amp_hi_p) << 19) + (AMP_W+PERS_W+1)'(amp_lo_p);
  assign amp_shr  = (AMP_W+3)'(amp_prod >> 16);
  assign amp_nxt  = (amp_shr > (AMP_W+3)'(AMP_CAP)) ? AMP_CAP : AMP_W'(amp_shr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        buf_v_r <= 1'b1;
      end else if (load) begin
        buf_v_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (en && busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_x_r <= mag_x;
      mag_y_r <= mag_y;
    end
    if (load) begin
      px_r  <= mag_x_r * base_frequency;
      py_r  <= mag_y_r * base_frequency;
      cnt_r <= cnt_nxt;
      k_r   <= '0;
      amp_r <= AMP_ONE;
    end else if (en && busy_r && !last) begin
      k_r   <= k_r + 1'b1;
      amp_r <= amp_nxt;
    end
  end

  // y drives the first lattice axis, x the second
  assign sy = SW'(py_r) << k_r;
  assign sx = SW'(px_r) << k_r;

  assign tok_valid     = busy_r;
  assign tok_tag.live  = (cnt_r != '0);
  assign tok_tag.first = (k_r == '0);
  assign tok_tag.last  = last;
  assign tok_x   = sy[FRAC_BITS+16 +: 32] + 32'(seed_offset);
  assign tok_y   = sx[FRAC_BITS+16 +: 32] + 32'(seed_offset);
  assign tok_xf  = sy[16 +: FRAC_BITS];
  assign tok_yf  = sx[16 +: FRAC_BITS];
  assign tok_amp = amp_r;

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != '0 |-> k_r < cnt_r)
    else $error("octave index past count");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !en |=> $stable(k_r) && $stable(amp_r) && busy_r)
    else $error("issuer moved while pipeline held");
  a_buf_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && buf_v_r |-> load)
    else $error("buffered item overwritten");
`endif

endmodule
`default_nettype wire

// ===== rtl/ovn_octave.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovn_octave #(
  parameter int FRAC_BITS = ovn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      tok_valid,
  input  wire ovn_pkg::tag_t             tok_tag,
  input  wire logic [31:0]               tok_x,
  input  wire logic [31:0]               tok_y,
  input  wire logic [FRAC_BITS-1:0]      tok_xf,
  input  wire logic [FRAC_BITS-1:0]      tok_yf,
  input  wire logic [ovn_pkg::AMP_W-1:0] tok_amp,
  output logic                           res_valid,
  output ovn_pkg::tag_t                  res_tag,
  output logic signed [63:0]             res_contrib
);
  import ovn_pkg::*;

  localparam int NS = 12;
  localparam int WW = FRAC_BITS + 1;
  localparam int LW = CW + FRAC_BITS + 2;
  localparam int PW = VW + AMP_W + 1;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  // sideband shift line, stage 0 is the entry register
  logic              v_r   [0:NS];
  tag_t              tag_r [0:NS];
  logic [AMP_W-1:0]  amp_r [0:NS];

  logic [31:0] x0_r, y0_r;
  logic [FRAC_BITS-1:0] xf0_r, yf0_r, xf1_r, yf1_r;
  logic [FRAC_BITS-1:0] a2x1_r, a2y1_r, a2x2_r, a2y2_r, a3x2_r, a3y2_r;
  logic [WW-1:0] wx_r [3:8];
  logic [WW-1:0] wy_r [3:8];
  logic [2*FRAC_BITS-1:0] sqx, sqy, cbx, cby;
  logic [FRAC_BITS+1:0] tx, ty;

  logic [31:0] hx [16];
  logic [31:0] hy [16];
  logic signed [31:0] hv [16];
  logic signed [CW-1:0] e [16];

  logic signed [CW-1:0] c00_r, c10_r, c01_r, c11_r;
  logic signed [LW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [CW-1:0] v1_r, v2_r;
  logic signed [LW-1:0] sum_ab, sum_cd, sum_ef;
  logic signed [CW-1:0] vv;
  logic signed [VW-1:0] v24_r;
  logic signed [VW+20:0] plo_r;
  logic signed [VW+18:0] phi_r;
  logic signed [PW-1:0] prod;
  logic signed [63:0] contrib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= tok_valid;
      for (int i = 1; i <= NS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tok_tag;
      amp_r[0] <= tok_amp;
      for (int i = 1; i <= NS; i++) begin
        tag_r[i] <= tag_r[i-1];
        amp_r[i] <= amp_r[i-1];
      end
      x0_r  <= tok_x;
      y0_r  <= tok_y;
      xf0_r <= tok_xf;
      yf0_r <= tok_yf;
    end
  end

  // lattice points around (X, Y)
  always_comb begin
    hx[0]  = x0_r - 1; hy[0]  = y0_r - 1;
    hx[1]  = x0_r + 1; hy[1]  = y0_r - 1;
    hx[2]  = x0_r - 1; hy[2]  = y0_r + 1;
    hx[3]  = x0_r + 1; hy[3]  = y0_r + 1;
    hx[4]  = x0_r - 1; hy[4]  = y0_r;
    hx[5]  = x0_r + 1; hy[5]  = y0_r;
    hx[6]  = x0_r;     hy[6]  = y0_r - 1;
    hx[7]  = x0_r;     hy[7]  = y0_r + 1;
    hx[8]  = x0_r;     hy[8]  = y0_r;
    hx[9]  = x0_r + 2; hy[9]  = y0_r - 1;
    hx[10] = x0_r + 2; hy[10] = y0_r + 1;
    hx[11] = x0_r + 2; hy[11] = y0_r;
    hx[12] = x0_r - 1; hy[12] = y0_r + 2;
    hx[13] = x0_r + 1; hy[13] = y0_r + 2;
    hx[14] = x0_r;     hy[14] = y0_r + 2;
    hx[15] = x0_r + 2; hy[15] = y0_r + 2;
  end

  for (genvar g = 0; g < 16; g++) begin : g_hash
    ovn_hash u_hash (
      .clk (clk),
      .en  (en),
      .x   (hx[g]),
      .y   (hy[g]),
      .val (hv[g])
    );
    assign e[g] = CW'(hv[g]);
  end

  // smoothstep weights, in step with the hash stages
  assign sqx = xf0_r * xf0_r;
  assign sqy = yf0_r * yf0_r;
  assign cbx = a2x1_r * xf1_r;
  assign cby = a2y1_r * yf1_r;
  assign tx  = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(a2x2_r)
               - (FRAC_BITS+2)'(2) * (FRAC_BITS+2)'(a3x2_r);
  assign ty  = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(a2y2_r)
               - (FRAC_BITS+2)'(2) * (FRAC_BITS+2)'(a3y2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a2x1_r <= sqx[FRAC_BITS +: FRAC_BITS];
      a2y1_r <= sqy[FRAC_BITS +: FRAC_BITS];
      xf1_r  <= xf0_r;
      yf1_r  <= yf0_r;
      a2x2_r <= a2x1_r;
      a2y2_r <= a2y1_r;
      a3x2_r <= cbx[FRAC_BITS +: FRAC_BITS];
      a3y2_r <= cby[FRAC_BITS +: FRAC_BITS];
      wx_r[3] <= (tx > (FRAC_BITS+2)'(ONE)) ? ONE : WW'(tx);
      wy_r[3] <= (ty > (FRAC_BITS+2)'(ONE)) ? ONE : WW'(ty);
      for (int i = 4; i <= 8; i++) begin
        wx_r[i] <= wx_r[i-1];
        wy_r[i] <= wy_r[i-1];
      end
    end
  end

  assign sum_ab = pa_r + pb_r;
  assign sum_cd = pc_r + pd_r;
  assign sum_ef = pe_r + pf_r;
  assign vv     = CW'(sum_ef >>> FRAC_BITS);
  assign prod   = (PW'(phi_r) <<< 20) + PW'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 6: smoothed corners
      c00_r <= (e[0] + e[1] + e[2] + e[3]) + 2 * (e[4] + e[5] + e[6] + e[7]) + 4 * e[8];
      c10_r <= (e[6] + e[9] + e[7] + e[10]) + 2 * (e[8] + e[11] + e[1] + e[3]) + 4 * e[5];
      c01_r <= (e[4] + e[5] + e[12] + e[13]) + 2 * (e[2] + e[3] + e[8] + e[14]) + 4 * e[7];
      c11_r <= (e[8] + e[11] + e[14] + e[15]) + 2 * (e[7] + e[10] + e[5] + e[13])
               + 4 * e[3];
      // stage 7: blend along the first axis
      pa_r <= LW'(c00_r) * LW'(signed'({1'b0, ONE - wx_r[6]}));
      pb_r <= LW'(c10_r) * LW'(signed'({1'b0, wx_r[6]}));
      pc_r <= LW'(c01_r) * LW'(signed'({1'b0, ONE - wx_r[6]}));
      pd_r <= LW'(c11_r) * LW'(signed'({1'b0, wx_r[6]}));
      // stage 8
      v1_r <= CW'(sum_ab >>> FRAC_BITS);
      v2_r <= CW'(sum_cd >>> FRAC_BITS);
      // stage 9: blend along the second axis
      pe_r <= LW'(v1_r) * LW'(signed'({1'b0, ONE - wy_r[8]}));
      pf_r <= LW'(v2_r) * LW'(signed'({1'b0, wy_r[8]}));
      // stage 10: floor to Q3.24
      v24_r <= VW'(vv >>> 10);
      // stage 11: amplitude in two partial products
      plo_r <= (VW+21)'(v24_r) * (VW+21)'(signed'({1'b0, amp_r[10][19:0]}));
      phi_r <= (VW+19)'(v24_r) * (VW+19)'(signed'({1'b0, amp_r[10][AMP_W-1:20]}));
      // stage 12
      contrib_r <= 64'(prod >>> 16);
    end
  end

  assign res_valid   = v_r[NS];
  assign res_tag     = tag_r[NS];
  assign res_contrib = contrib_r;

endmodule
`default_nettype wire

// ===== rtl/ovn_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovn_accum (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           res_valid,
  input  wire ovn_pkg::tag_t                  res_tag,
  input  wire logic signed [63:0]             res_contrib,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ovn_pkg::HEIGHT_W-1:0]        height
);
  import ovn_pkg::*;

  localparam logic signed [63:0] SAT_MAX = 64'sh000000007fffffff;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000000080000000;

  logic signed [63:0] acc_r, acc_nxt;
  logic               out_valid_r;
  logic [HEIGHT_W-1:0] height_r, height_nxt;

  assign acc_nxt = (res_tag.first ? 64'sd0 : acc_r) + (res_tag.live ? res_contrib : 64'sd0);

  always_comb begin
    if (acc_nxt > SAT_MAX) begin
      height_nxt = HEIGHT_W'(SAT_MAX);
    end else if (acc_nxt < SAT_MIN) begin
      height_nxt = HEIGHT_W'(SAT_MIN);
    end else begin
      height_nxt = HEIGHT_W'(acc_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && res_valid && res_tag.last) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res_valid) begin
      acc_r <= acc_nxt;
      if (res_tag.last) begin
        height_r <= height_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign height    = height_r;

endmodule
`default_nettype wire

// ===== rtl/octave_value_noise_2d.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_stall     in_coord_x, in_coord_y (signed Q16.FRAC_BITS)
// out      out_valid / out_stall   out_height (signed Q8.24, saturated)
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One point takes max(octave_count, 1) octave steps of the issuer, clamped to
// MAX_OCTAVES; the issuer steps one octave a cycle into the octave pipeline
// while the pipeline is not held. Points overlap in flight.
// Reset clears control state and loads the register defaults; no clearing pass.
// A held result with out_stall high freezes the issuer, octave and accumulator stages in place.
`timescale 1ns / 1ps
`default_nettype none
module octave_value_noise_2d #(
  parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = ovn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [ovn_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic signed [ovn_pkg::COORD_W-1:0] in_coord_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ovn_pkg::HEIGHT_W-1:0]    out_height,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ovn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ovn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ovn_pkg::*;

  logic [PERS_W-1:0] persistence_r;
  logic [FREQ_W-1:0] base_frequency_r;
  logic [OCT_W-1:0]  octave_count_r;
  logic [SEED_W-1:0] seed_offset_r;

  logic                 en;
  logic                 tok_valid;
  tag_t                 tok_tag;
  logic [31:0]          tok_x, tok_y;
  logic [FRAC_BITS-1:0] tok_xf, tok_yf;
  logic [AMP_W-1:0]     tok_amp;
  logic                 res_valid;
  tag_t                 res_tag;
  logic signed [63:0]   res_contrib;
  logic [HEIGHT_W-1:0]  height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persistence_r    <= PERS_W'(32768);
      base_frequency_r <= FREQ_W'(65536);
      octave_count_r   <= OCT_W'(4);
      seed_offset_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERSISTENCE:    persistence_r    <= cfg_data[PERS_W-1:0];
        REG_BASE_FREQUENCY: base_frequency_r <= cfg_data[FREQ_W-1:0];
        REG_OCTAVE_COUNT:   octave_count_r   <= cfg_data[OCT_W-1:0];
        REG_SEED_OFFSET:    seed_offset_r    <= cfg_data[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // advance everything unless a finished result is held
  assign en = !(out_valid && out_stall);

  ovn_issue #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_issue (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .coord_x        (in_coord_x),
    .coord_y        (in_coord_y),
    .persistence    (persistence_r),
    .base_frequency (base_frequency_r),
    .octave_count   (octave_count_r),
    .seed_offset    (seed_offset_r),
    .tok_valid      (tok_valid),
    .tok_tag        (tok_tag),
    .tok_x          (tok_x),
    .tok_y          (tok_y),
    .tok_xf         (tok_xf),
    .tok_yf         (tok_yf),
    .tok_amp        (tok_amp)
  );

  ovn_octave #(
    .FRAC_BITS (FRAC_BITS)
  ) u_octave (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .tok_valid   (tok_valid),
    .tok_tag     (tok_tag),
    .tok_x       (tok_x),
    .tok_y       (tok_y),
    .tok_xf      (tok_xf),
    .tok_yf      (tok_yf),
    .tok_amp     (tok_amp),
    .res_valid   (res_valid),
    .res_tag     (res_tag),
    .res_contrib (res_contrib)
  );

  ovn_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .res_valid   (res_valid),
    .res_tag     (res_tag),
    .res_contrib (res_contrib),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .height      (height)
  );

  assign out_height = signed'(height);

endmodule
`default_nettype wire

// ===== test/octave_value_noise_2d_tb.sv =====
`timescale 1ns / 1ps
module octave_value_noise_2d_tb;
  import ovn_pkg::*;

  localparam bit [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam bit [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int N_OCT_MAX = 8;
  localparam int FB = 16;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [HEIGHT_W-1:0] out_height;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed expectation that travels with the item being offered
  logic typed_on = 1'b0;
  logic [31:0] typed_val = '0;

  bit [17:0] pers_q = 18'd32768;
  bit [23:0] freq_q = 24'd65536;
  bit [3:0] oct_q = 4'd4;
  bit [15:0] seed_q = 16'd0;

  logic [31:0] height_due[$];
  int errors = 0;
  bit hold_req = 1'b0;

  typedef struct {
    bit [3:0] oct;
    bit [31:0] x;
    bit [31:0] y;
    bit typed;
    bit [31:0] exp;
  } dir_row_t;

  dir_row_t dir_rows[16];

  octave_value_noise_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_height(out_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint lattice_val(bit [31:0] a, bit [31:0] b);
    bit [31:0] n;
    bit [31:0] t;
    n = a + b * 32'd57;
    n = (n << 13) ^ n;
    t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return longint'(32'h40000000) - longint'(t);
  endfunction

  function automatic longint smooth_mix(longint p, longint q, bit [31:0] f);
    longint a2;
    longint a3;
    longint w;
    a2 = (longint'(f) * longint'(f)) >>> FB;
    a3 = (a2 * longint'(f)) >>> FB;
    w = 3 * a2 - 2 * a3;
    if (w > (64'sd1 <<< FB)) w = 64'sd1 <<< FB;
    return (p * ((64'sd1 <<< FB) - w) + q * w) >>> FB;
  endfunction

  function automatic longint octave_val(bit [31:0] X, bit [31:0] Xf, bit [31:0] Y,
                                        bit [31:0] Yf);
    longint n01, n02, n03, n04, n05, n06, n07, n08, n09;
    longint n12, n14, n16, n23, n24, n28, n34;
    longint c00, c10, c01, c11;
    n01 = lattice_val(X - 1, Y - 1); n02 = lattice_val(X + 1, Y - 1);
    n03 = lattice_val(X - 1, Y + 1); n04 = lattice_val(X + 1, Y + 1);
    n05 = lattice_val(X - 1, Y);     n06 = lattice_val(X + 1, Y);
    n07 = lattice_val(X, Y - 1);     n08 = lattice_val(X, Y + 1);
    n09 = lattice_val(X, Y);
    n12 = lattice_val(X + 2, Y - 1); n14 = lattice_val(X + 2, Y + 1);
    n16 = lattice_val(X + 2, Y);
    n23 = lattice_val(X - 1, Y + 2); n24 = lattice_val(X + 1, Y + 2);
    n28 = lattice_val(X, Y + 2);
    n34 = lattice_val(X + 2, Y + 2);
    c00 = (n01 + n02 + n03 + n04) + 2 * (n05 + n06 + n07 + n08) + 4 * n09;
    c10 = (n07 + n12 + n08 + n14) + 2 * (n09 + n16 + n02 + n04) + 4 * n06;
    c01 = (n05 + n06 + n23 + n24) + 2 * (n03 + n04 + n09 + n28) + 4 * n08;
    c11 = (n09 + n16 + n28 + n34) + 2 * (n08 + n14 + n06 + n24) + 4 * n04;
    return smooth_mix(smooth_mix(c00, c10, Xf), smooth_mix(c01, c11, Xf), Yf);
  endfunction

  function automatic bit [31:0] noise_height(bit [31:0] cx, bit [31:0] cy);
    bit [31:0] mx, my, X, Y, Xf, Yf;
    bit [63:0] px, py, amp;
    longint sum, v24;
    int cnt;
    mx = cx[31] ? -cx : cx;
    my = cy[31] ? -cy : cy;
    px = 64'(mx) * 64'(freq_q);
    py = 64'(my) * 64'(freq_q);
    cnt = (oct_q > N_OCT_MAX) ? N_OCT_MAX : int'(oct_q);
    amp = 64'd65536;
    sum = 0;
    for (int k = 0; k < cnt; k++) begin
      // y scales the first lattice axis, x the second
      X = 32'(py >> (32 - k)) + 32'(seed_q);
      Y = 32'(px >> (32 - k)) + 32'(seed_q);
      Xf = 32'((py << k) >> 16) & 32'hffff;
      Yf = 32'((px << k) >> 16) & 32'hffff;
      v24 = octave_val(X, Xf, Y, Yf) >>> 10;
      sum += (v24 * longint'(amp)) >>> 16;
      amp = (amp * 64'(pers_q)) >> 16;
      if (amp > 64'(AMP_CAP)) amp = 64'(AMP_CAP);
    end
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // track config, predict on accepted items, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERSISTENCE:    pers_q = cfg_data[17:0];
          REG_BASE_FREQUENCY: freq_q = cfg_data[23:0];
          REG_OCTAVE_COUNT:   oct_q = cfg_data[3:0];
          REG_SEED_OFFSET:    seed_q = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        height_due.push_back(typed_on ? typed_val : noise_height(in_coord_x, in_coord_y));
      if (out_valid && !out_stall) begin
        if (height_due.size() == 0) begin
          $error("unexpected item: height %h", out_height);
          errors++;
        end else begin
          logic [31:0] want;
          want = height_due.pop_front();
          if (out_height !== want) begin
            $error("height: expected %h, actual %h", want, out_height);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int r;
    int len;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall <= 1'b0;
          len = $urandom_range(50, 150);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    while (height_due.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic offer(bit [31:0] x, bit [31:0] y, bit typed, bit [31:0] exp, bit gaps);
    int r;
    int gap;
    gap = 0;
    if (gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    typed_on <= typed;
    typed_val <= exp;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic bit [31:0] rand_coord();
    bit [31:0] edges[6] = '{32'h0, 32'h1, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                            32'h00010000};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed(32'($urandom_range(0, 32'h80000)) - 32'h40000));
      2: return edges[$urandom_range(0, 5)];
      default: return $urandom & 32'h00ffffff;
    endcase
  endfunction

  initial begin
    bit [23:0] pv, fv, ov, sv;
    dir_rows = '{
      '{4'd0, 32'h00000000, 32'h00000000, 1'b1, 32'h0},
      '{4'd0, 32'h7fffffff, 32'h80000000, 1'b1, 32'h0},
      '{4'd0, 32'h80000000, 32'h00000001, 1'b1, 32'h0},
      '{4'd4, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
      '{4'd4, 32'h00000001, 32'h00000001, 1'b0, 32'h0},
      '{4'd4, 32'h7fffffff, 32'h7fffffff, 1'b0, 32'h0},
      '{4'd4, 32'h80000000, 32'h80000000, 1'b0, 32'h0},
      '{4'd4, 32'h80000000, 32'h7fffffff, 1'b0, 32'h0},
      '{4'd4, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
      '{4'd4, 32'h00010000, 32'h00020000, 1'b0, 32'h0},
      '{4'd4, 32'h0000ffff, 32'hffff0000, 1'b0, 32'h0},
      '{4'd15, 32'h12345678, 32'hffffedcc, 1'b0, 32'h0},
      '{4'd15, 32'h80000000, 32'h7fffffff, 1'b0, 32'h0},
      '{4'd1, 32'h00018000, 32'h7fff8000, 1'b0, 32'h0},
      '{4'd8, 32'h00008000, 32'h00004000, 1'b0, 32'h0},
      '{4'd8, 32'hdeadbeef, 32'h0badf00d, 1'b0, 32'h0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].oct != oct_q) begin
        in_valid <= 1'b0;
        drain();
        cfg_write(REG_OCTAVE_COUNT, 24'(dir_rows[i].oct));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      offer(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].exp, 1'b0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      case (p)
        0: begin pv = 24'hffffff; fv = 24'hffffff; ov = 24'hfffff8; sv = 24'hffffff; end
        1: begin pv = 24'h0; fv = 24'h0; ov = 24'h3; sv = 24'h0; end
        2: begin pv = 24'h10000; fv = 24'h10000; ov = 24'h0; sv = 24'h1234; end
        default: begin
          pv = 24'($urandom);
          fv = 24'($urandom);
          ov = 24'($urandom_range(0, 15));
          sv = 24'($urandom);
        end
      endcase
      cfg_write(REG_PERSISTENCE, pv);
      cfg_write(REG_BASE_FREQUENCY, fv);
      cfg_write(REG_OCTAVE_COUNT, ov);
      cfg_write(REG_SEED_OFFSET, sv);
      // spare indexes must leave every register alone
      if (p == 2) begin
        cfg_write(REG_SPARE_LO, 24'hffffff);
        cfg_write(REG_SPARE_HI, 24'($urandom));
      end
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (p == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        offer(rand_coord(), rand_coord(), 1'b0, 32'h0, 1'b1);
    end
    in_valid <= 1'b0;

    for (int w = 0; w < 200000 && height_due.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && height_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (height_due.size() != 0) $error("%0d items never came out", height_due.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

endmodule
